### hw/rtl/hpo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpo_pkg: shared types and constants of the haversine path odometer
// Fixed-point constants, CORDIC arctangent table and the command and status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package hpo_pkg;

  localparam int unsigned LAT_W   = 31;
  localparam int unsigned LON_W   = 32;
  localparam int unsigned TOT_W   = 48;
  localparam int unsigned RAD_W   = 24;
  localparam int unsigned CW      = 34;  // CORDIC and angle datapath width
  localparam int unsigned PW      = 68;  // multiplier product width
  localparam int unsigned ADDR_W  = 3;

  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sh026DD3B6A;
  localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [CW-1:0] DEG180_E7   = 34'sd1800000000;
  localparam logic signed [CW-1:0] DEG360_E7   = 34'sd3600000000;

  localparam logic [31:0] DIV_HALF_ANG  = 32'd3600000000;
  localparam logic [31:0] DIV_FULL_ANG  = 32'd1800000000;
  localparam logic [31:0] RND_HALF_ANG  = 32'd1800000000;
  localparam logic [31:0] RND_FULL_ANG  = 32'd900000000;

  // floor(2^63 / divisor): quotient estimate from the upper dividend word
  localparam logic signed [CW-1:0] RCP_HALF_ANG = 34'sd2562047788;
  localparam logic signed [CW-1:0] RCP_FULL_ANG = 34'sd5124095576;

  localparam logic [TOT_W-1:0] TOTAL_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 24'd6371000;

  localparam logic [4:0] DIV_LAST  = 5'd7;
  localparam logic [4:0] CORD_LAST = 5'd30;
  localparam logic [4:0] SQRT_LAST = 5'd31;

  localparam logic [ADDR_W-1:0] REG_RADIUS = 3'd0;

  typedef enum logic [4:0] {
    OP_NONE   = 5'd0,
    OP_LOAD   = 5'd1,
    OP_DIFF   = 5'd2,
    OP_RMUL   = 5'd3,
    OP_DINIT  = 5'd4,
    OP_DSTEP  = 5'd5,
    OP_RINIT  = 5'd6,
    OP_RSTEP  = 5'd7,
    OP_POST   = 5'd8,
    OP_STORE  = 5'd9,
    OP_AMUL   = 5'd10,
    OP_ASUM   = 5'd11,
    OP_SINIT  = 5'd12,
    OP_SSTEP  = 5'd13,
    OP_SSTORE = 5'd14,
    OP_VINIT  = 5'd15,
    OP_VSTEP  = 5'd16,
    OP_DMUL   = 5'd17,
    OP_ACC    = 5'd18,
    OP_COMMIT = 5'd19
  } hpo_op_e;

  typedef struct packed {
    hpo_op_e    op;
    logic [1:0] sel;
  } hpo_cmd_t;

  typedef struct packed {
    logic have_first;
    logic last;
  } hpo_sts_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:  v = 34'sh3243F6A8;
      5'd1:  v = 34'sh1DAC6705;
      5'd2:  v = 34'sh0FADBAFC;
      5'd3:  v = 34'sh07F56EA6;
      5'd4:  v = 34'sh03FEAB76;
      5'd5:  v = 34'sh01FFD55B;
      5'd6:  v = 34'sh00FFFAAA;
      5'd7:  v = 34'sh007FFF55;
      5'd8:  v = 34'sh003FFFEA;
      5'd9:  v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      5'd24: v = 34'sh0000003F;
      5'd25: v = 34'sh0000001F;
      5'd26: v = 34'sh0000000F;
      5'd27: v = 34'sh00000008;
      5'd28: v = 34'sh00000004;
      5'd29: v = 34'sh00000002;
      5'd30: v = 34'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/hpo_fix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpo_fix_if: GPS fix channel
// Valid/ready channel carrying one latitude/longitude fix per transaction.
// ----------------------------------------------------------------------------
interface hpo_fix_if import hpo_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] lat_e7;
  logic signed [LON_W-1:0] lon_e7;

  modport source (output valid, lat_e7, lon_e7, input ready);
  modport sink   (input valid, lat_e7, lon_e7, output ready);
endinterface

### hw/rtl/hpo_total_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpo_total_if: path total channel
// Valid/ready channel carrying the accumulated path length per transaction.
// ----------------------------------------------------------------------------
interface hpo_total_if import hpo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TOT_W-1:0] total_mm;

  modport source (output valid, total_mm, input ready);
  modport sink   (input valid, total_mm, output ready);
endinterface

### hw/rtl/hpo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpo_ctrl: odometer sequencer
// One-hot state machine that steps the datapath through conversion, CORDIC,
// square root and accumulation, and owns the result valid flag.
// ----------------------------------------------------------------------------
module hpo_ctrl import hpo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  hpo_sts_t sts_i,
  output hpo_cmd_t cmd_o
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_DIFF   = 19'h00002,
    S_RMUL   = 19'h00004,
    S_DINIT  = 19'h00008,
    S_DSTEP  = 19'h00010,
    S_RINIT  = 19'h00020,
    S_RSTEP  = 19'h00040,
    S_POST   = 19'h00080,
    S_STORE  = 19'h00100,
    S_AMUL   = 19'h00200,
    S_ASUM   = 19'h00400,
    S_SINIT  = 19'h00800,
    S_SSTEP  = 19'h01000,
    S_SSTORE = 19'h02000,
    S_VINIT  = 19'h04000,
    S_VSTEP  = 19'h08000,
    S_DMUL   = 19'h10000,
    S_ACC    = 19'h20000,
    S_COMMIT = 19'h40000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_NONE;
    cmd_o.sel   = sel_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = sts_i.have_first ? S_DIFF : S_COMMIT;
        end
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        sel_d    = 2'd0;
        state_d  = S_RMUL;
      end
      S_RMUL: begin
        cmd_o.op = OP_RMUL;
        state_d  = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = OP_DINIT;
        state_d  = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.op = OP_DSTEP;
        if (sts_i.last) state_d = S_RINIT;
      end
      S_RINIT: begin
        cmd_o.op = OP_RINIT;
        state_d  = S_RSTEP;
      end
      S_RSTEP: begin
        cmd_o.op = OP_RSTEP;
        if (sts_i.last) state_d = S_POST;
      end
      S_POST: begin
        cmd_o.op = OP_POST;
        state_d  = S_STORE;
      end
      S_STORE: begin
        cmd_o.op = OP_STORE;
        if (sel_q == 2'd3) begin
          state_d = S_AMUL;
        end else begin
          sel_d   = sel_q + 2'd1;
          state_d = S_RMUL;
        end
      end
      S_AMUL: begin
        cmd_o.op = OP_AMUL;
        state_d  = S_ASUM;
      end
      S_ASUM: begin
        cmd_o.op = OP_ASUM;
        sel_d    = 2'd0;
        state_d  = S_SINIT;
      end
      S_SINIT: begin
        cmd_o.op = OP_SINIT;
        state_d  = S_SSTEP;
      end
      S_SSTEP: begin
        cmd_o.op = OP_SSTEP;
        if (sts_i.last) state_d = S_SSTORE;
      end
      S_SSTORE: begin
        cmd_o.op = OP_SSTORE;
        if (sel_q == 2'd0) begin
          sel_d   = 2'd1;
          state_d = S_SINIT;
        end else begin
          state_d = S_VINIT;
        end
      end
      S_VINIT: begin
        cmd_o.op = OP_VINIT;
        state_d  = S_VSTEP;
      end
      S_VSTEP: begin
        cmd_o.op = OP_VSTEP;
        if (sts_i.last) state_d = S_DMUL;
      end
      S_DMUL: begin
        cmd_o.op = OP_DMUL;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register is free
        if (slot_free) begin
          cmd_o.op    = OP_COMMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_COMMIT) |-> slot_free)
    else $error("result committed over an untaken result");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_COMMIT) |=> out_valid_o)
    else $error("committed result not presented");

endmodule

### hw/rtl/hpo_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpo_dp: odometer datapath
// Fix registers, shared multiplier, reciprocal-multiply degree-to-radian
// scaling, shared rotation/vectoring CORDIC, bitwise square root, saturating
// total accumulator and result register.
// ----------------------------------------------------------------------------
module hpo_dp import hpo_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hpo_cmd_t                cmd_i,
  output hpo_sts_t                sts_o,
  input  logic signed [LAT_W-1:0] lat_i,
  input  logic signed [LON_W-1:0] lon_i,
  input  logic [RAD_W-1:0]        radius_i,
  output logic [TOT_W-1:0]        total_o
);

  // architectural state
  logic signed [LAT_W-1:0] plat_q;
  logic signed [LON_W-1:0] plon_q;
  logic                    have_first_q;
  logic [TOT_W-1:0]        total_q, total_d;
  logic [TOT_W-1:0]        out_total_q;

  // work registers
  logic signed [LAT_W-1:0] lat_q;
  logic signed [LON_W-1:0] lon_q;
  logic signed [CW-1:0]    dlat_q, dlon_q;
  logic [30:0]             r125_q;
  logic signed [PW-1:0]    prod_q;
  logic                    neg_q, cneg_q;
  logic [63:0]             n_q;
  logic [35:0]             rem_q;
  logic [31:0]             quo_q;
  logic signed [CW-1:0]    cx_q, cy_q, cz_q;
  logic [4:0]              cnt_q;
  logic signed [CW-1:0]    sl_q, so_q, cc_q, c1_q;
  logic [30:0]             a_q;
  logic [63:0]             sv_q, sr_q, sbit_q;
  logic [30:0]             s_q, t_q;

  // combinational
  logic signed [CW-1:0]    dl_raw, dn_raw, dl_w1, dn_w1, dl_w2, dn_w2;
  logic signed [CW-1:0]    conv_v, conv_abs;
  logic signed [CW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    mul_p;
  logic [31:0]             div_c, rnd_c;
  logic signed [CW-1:0]    rcp_c;
  logic [63:0]             dsum;
  logic [31:0]             est;
  logic signed [CW-1:0]    qs, rz;
  logic signed [CW-1:0]    dx, dy, at;
  logic                    udir;
  logic signed [CW-1:0]    cosv;
  logic signed [PW-1:0]    psh;
  logic signed [CW:0]      asum;
  logic [30:0]             a_sel;
  logic [63:0]             sinit_v, srb;
  logic signed [CW-1:0]    zc;
  logic [36:0]             mm;
  logic [TOT_W-1:0]        headroom;

  assign sts_o.have_first = have_first_q;
  assign sts_o.last = (cmd_i.op == OP_RSTEP || cmd_i.op == OP_VSTEP) ?
                      (cnt_q == CORD_LAST) :
                      ((cmd_i.op == OP_DSTEP) ? (cnt_q == DIV_LAST) :
                                                (cnt_q == SQRT_LAST));
  assign total_o = out_total_q;

  // wrap differences into [-180, 180) degrees
  always_comb begin
    dl_raw = CW'(lat_q) - CW'(plat_q);
    dn_raw = CW'(lon_q) - CW'(plon_q);
    dl_w1  = (dl_raw >= DEG180_E7) ? dl_raw - DEG360_E7 : dl_raw;
    dn_w1  = (dn_raw >= DEG180_E7) ? dn_raw - DEG360_E7 : dn_raw;
    dl_w2  = (dl_w1 < -DEG180_E7) ? dl_w1 + DEG360_E7 : dl_w1;
    dn_w2  = (dn_w1 < -DEG180_E7) ? dn_w1 + DEG360_E7 : dn_w1;
  end

  always_comb begin
    case (cmd_i.sel)
      2'd0:    conv_v = dlat_q;
      2'd1:    conv_v = dlon_q;
      2'd2:    conv_v = CW'(plat_q);
      default: conv_v = CW'(lat_q);
    endcase
    conv_abs = (conv_v < 0) ? -conv_v : conv_v;
    div_c    = cmd_i.sel[1] ? DIV_FULL_ANG : DIV_HALF_ANG;
    rnd_c    = cmd_i.sel[1] ? RND_FULL_ANG : RND_HALF_ANG;
    rcp_c    = cmd_i.sel[1] ? RCP_FULL_ANG : RCP_HALF_ANG;
    dsum     = prod_q[63:0] + {32'd0, rnd_c};
    // estimate is at most four below the true quotient
    est      = prod_q[62:31];
  end

  // angle set-up for the rotation pass
  always_comb begin
    qs = {2'b00, quo_q};
    if (cmd_i.sel[1]) begin
      rz = (qs > HALF_PI_Q30) ? PI_Q30 - qs : qs;
    end else begin
      rz = neg_q ? -qs : qs;
    end
  end

  always_comb begin
    dx   = cy_q >>> cnt_q;
    dy   = cx_q >>> cnt_q;
    at   = atan_q30(cnt_q);
    udir = (cmd_i.op == OP_RSTEP) ? (cz_q >= 0) : (cy_q < 0);
    cosv = cneg_q ? -cx_q : cx_q;
    psh  = prod_q >>> 30;
  end

  always_comb begin
    asum = (CW+1)'(sl_q) + $signed(psh[CW:0]);
    if (asum < 0) begin
      a_sel = '0;
    end else if (asum > (CW+1)'(ONE_Q30)) begin
      a_sel = ONE_Q30[30:0];
    end else begin
      a_sel = asum[30:0];
    end
    sinit_v = cmd_i.sel[0] ? {3'd0, ONE_Q30[30:0] - a_q, 30'd0} : {3'd0, a_q, 30'd0};
    srb     = sr_q + sbit_q;
  end

  always_comb begin
    if (cz_q < 0) begin
      zc = '0;
    end else if (cz_q > HALF_PI_Q30) begin
      zc = HALF_PI_Q30;
    end else begin
      zc = cz_q;
    end
    mm       = 37'((prod_q[63:0] + 64'd67108864) >> 27);
    headroom = TOTAL_MAX - total_q;
    total_d  = ({11'd0, mm} >= headroom) ? TOTAL_MAX : total_q + {11'd0, mm};
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_RMUL: begin
        mul_a = conv_abs;
        mul_b = PI_Q30;
      end
      OP_DSTEP: begin
        if (cnt_q == 5'd0) begin
          mul_a = {2'b00, n_q[63:32]};
          mul_b = rcp_c;
        end else begin
          mul_a = {2'b00, est};
          mul_b = {2'b00, div_c};
        end
      end
      OP_POST: begin
        if (cmd_i.sel == 2'd3) begin
          mul_a = c1_q;
          mul_b = cosv;
        end else begin
          mul_a = cy_q;
          mul_b = cy_q;
        end
      end
      OP_AMUL: begin
        mul_a = cc_q;
        mul_b = so_q;
      end
      OP_DMUL: begin
        mul_a = {zc[CW-2:0], 1'b0};
        mul_b = {3'd0, r125_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plat_q       <= '0;
      plon_q       <= '0;
      have_first_q <= 1'b0;
      total_q      <= '0;
    end else begin
      if (cmd_i.op == OP_ACC) total_q <= total_d;
      if (cmd_i.op == OP_COMMIT) begin
        plat_q       <= lat_q;
        plon_q       <= lon_q;
        have_first_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        lat_q <= lat_i;
        lon_q <= lon_i;
      end
      OP_DIFF: begin
        dlat_q <= dl_w2;
        dlon_q <= dn_w2;
        r125_q <= {radius_i, 7'd0} - {5'd0, radius_i, 2'd0} + {7'd0, radius_i};
      end
      OP_RMUL: begin
        neg_q  <= (conv_v < 0);
        prod_q <= mul_p;
      end
      OP_DINIT: begin
        n_q   <= dsum;
        cnt_q <= '0;
      end
      OP_DSTEP: begin
        // estimate, multiply back, then correct by compare and subtract
        if (cnt_q == 5'd0) begin
          prod_q <= mul_p;
        end else if (cnt_q == 5'd1) begin
          quo_q  <= est;
          prod_q <= mul_p;
        end else if (cnt_q == 5'd2) begin
          rem_q <= 36'(n_q - prod_q[63:0]);
        end else if (rem_q >= {4'd0, div_c}) begin
          rem_q <= rem_q - {4'd0, div_c};
          quo_q <= quo_q + 32'd1;
        end
        cnt_q <= cnt_q + 5'd1;
      end
      OP_RINIT: begin
        cneg_q <= cmd_i.sel[1] && (qs > HALF_PI_Q30);
        cx_q   <= GAIN_Q30;
        cy_q   <= '0;
        cz_q   <= rz;
        cnt_q  <= '0;
      end
      OP_RSTEP, OP_VSTEP: begin
        if (udir) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + at;
        end
        cnt_q <= cnt_q + 5'd1;
      end
      OP_POST: begin
        prod_q <= mul_p;
        if (cmd_i.sel == 2'd2) c1_q <= cosv;
      end
      OP_STORE: begin
        case (cmd_i.sel)
          2'd0:    sl_q <= psh[CW-1:0];
          2'd1:    so_q <= psh[CW-1:0];
          2'd3:    cc_q <= psh[CW-1:0];
          default: ;
        endcase
      end
      OP_AMUL: prod_q <= mul_p;
      OP_ASUM: a_q <= a_sel;
      OP_SINIT: begin
        sv_q   <= sinit_v;
        sr_q   <= '0;
        sbit_q <= 64'h4000_0000_0000_0000;
        cnt_q  <= '0;
      end
      OP_SSTEP: begin
        if (sv_q >= srb) begin
          sv_q <= sv_q - srb;
          sr_q <= (sr_q >> 1) + sbit_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
        cnt_q  <= cnt_q + 5'd1;
      end
      OP_SSTORE: begin
        if (cmd_i.sel[0]) t_q <= sr_q[30:0];
        else              s_q <= sr_q[30:0];
      end
      OP_VINIT: begin
        cx_q  <= {3'd0, t_q};
        cy_q  <= {3'd0, s_q};
        cz_q  <= '0;
        cnt_q <= '0;
      end
      OP_DMUL:   prod_q <= mul_p;
      OP_COMMIT: out_total_q <= total_q;
      default: ;
    endcase
  end

  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q >= $past(total_q))
    else $error("path total decreased");

  a_a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_ASUM) |=> (a_q <= ONE_Q30[30:0]))
    else $error("haversine term out of range");

  a_first_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DIFF) |-> have_first_q)
    else $error("distance computed without a previous fix");

endmodule

### hw/rtl/haversine_path_odometer.sv
`timescale 1ns / 1ps
// Sequence: a first fix after reset goes straight to the commit step; a later fix
// runs four angle passes (8-step reciprocal scaling and a 31-step CORDIC rotation),
// two 32-step square roots and a 31-step vectoring pass before it commits. A new fix
// is taken only when idle, after the last one commits; a result not yet taken
// holds the sequencer in its commit step. Reset is asynchronous, active low;
// it clears the previous fix, the total and the radius to 6371000 m.
// ----------------------------------------------------------------------------
// haversine_path_odometer: GPS path length accumulator
// Computes the great-circle distance between consecutive fixes and adds it to
// a saturating millimetre total; the earth radius is set over an APB port.
// ----------------------------------------------------------------------------
module haversine_path_odometer import hpo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  hpo_fix_if.sink             fix_in,
  hpo_total_if.source         total_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [RAD_W-1:0] radius_q;
  logic             reg_hit;
  hpo_cmd_t         cmd;
  hpo_sts_t         sts;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_RADIUS[ADDR_W-1:2]);
  assign prdata  = reg_hit ? {8'd0, radius_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      radius_q <= pwdata[RAD_W-1:0];
    end
  end

  hpo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fix_in.valid),
    .in_ready_o  (fix_in.ready),
    .out_valid_o (total_out.valid),
    .out_ready_i (total_out.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hpo_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .lat_i    (fix_in.lat_e7),
    .lon_i    (fix_in.lon_e7),
    .radius_i (radius_q),
    .total_o  (total_out.total_mm)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: haversine path odometer testbench
// Drives GPS fixes through the valid/ready fix channel with bursty gaps,
// predicts the saturating millimetre total in fixed point, and compares it
// with every total transaction while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
  import hpo_pkg::*;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } fix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  hpo_fix_if   fix_ch ();
  hpo_total_if tot_ch ();

  haversine_path_odometer i_dut (
    .clk_i, .rst_ni, .fix_in(fix_ch.sink), .total_out(tot_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [RAD_W-1:0] radius_m;
  longint prev_lat, prev_lon;
  bit got_first;
  longint unsigned run_total;

  fix_t fix_q[$];
  logic [TOT_W-1:0] total_q[$];
  int n_err = 0, n_fix = 0, n_tot = 0, n_rad = 0;
  bit drv_en = 1'b0;
  bit fix_taken = 1'b0;
  int burst_left = 0, gap_left = 0;

  localparam longint PI_L = 64'd3373259426;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint e7_to_q30(longint v, longint unsigned dv);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m * PI_L + dv / 2) / dv;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void rotate(longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = longint'(GAIN_Q30);
    y = 0;
    z = ang;
    for (int i = 0; i < 31; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint lat_cos(longint r);
    longint m, c, s;
    bit neg;
    m = (r < 0) ? -r : r;
    neg = 1'b0;
    if (m > longint'(HALF_PI_Q30)) begin
      m = PI_L - m;
      neg = 1'b1;
    end
    rotate(m, c, s);
    return neg ? -c : c;
  endfunction

  function automatic longint half_sin_sq(longint d);
    longint c, s;
    if (d >= 64'sd1800000000) d -= 64'sd3600000000;
    if (d < -64'sd1800000000) d += 64'sd3600000000;
    rotate(e7_to_q30(d, 64'd3600000000), c, s);
    return (s * s) >>> 30;
  endfunction

  function automatic longint bit_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vec_atan(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < 31; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
    return z;
  endfunction

  // advance the odometer by one fix and return the expected total
  function automatic logic [TOT_W-1:0] odometer_step(fix_t f);
    longint lat, lon, sl, so, cc, a, s, t, z;
    longint unsigned mm;
    lat = longint'(f.lat);
    lon = longint'(f.lon);
    if (!got_first) begin
      got_first = 1'b1;
    end else begin
      sl = half_sin_sq(lat - prev_lat);
      so = half_sin_sq(lon - prev_lon);
      cc = (lat_cos(e7_to_q30(prev_lat, 64'd1800000000)) *
            lat_cos(e7_to_q30(lat, 64'd1800000000))) >>> 30;
      a = sl + ((cc * so) >>> 30);
      if (a < 0) a = 0;
      if (a > longint'(ONE_Q30)) a = longint'(ONE_Q30);
      s = bit_sqrt(longint'(a) << 30);
      t = bit_sqrt((longint'(ONE_Q30) - a) << 30);
      z = vec_atan(t, s);
      mm = (longint'(2 * z) * longint'(radius_m) * 125 + (64'd1 << 26)) >> 27;
      run_total = (mm >= longint'(TOTAL_MAX) - run_total) ? longint'(TOTAL_MAX)
                                                            : run_total + mm;
    end
    prev_lat = lat;
    prev_lon = lon;
    return run_total[TOT_W-1:0];
  endfunction

  // record the fix handshake seen at the rising edge
  always @(posedge clk_i) begin
    fix_taken <= rst_ni && fix_ch.valid && fix_ch.ready;
  end

  // driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (fix_taken) begin
      void'(fix_q.pop_front());
    end
    if (fix_ch.valid && !fix_taken) begin
      // hold the pending transaction
    end else if (drv_en && fix_q.size() > 0 && gap_left == 0) begin
      fix_ch.valid <= 1'b1;
      fix_ch.lat_e7 <= fix_q[0].lat;
      fix_ch.lon_e7 <= fix_q[0].lon;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
      end else begin
        burst_left--;
      end
    end else begin
      fix_ch.valid <= 1'b0;
      if (gap_left > 0) gap_left--;
    end
  end

  // receiver stalls in its own pattern
  always @(negedge clk_i) begin
    tot_ch.ready <= ($urandom_range(0, 3) != 0) || (n_tot % 50 > 40);
  end

  // monitor: predict on accepted fixes, check on accepted totals
  always @(posedge clk_i) begin
    if (rst_ni && fix_ch.valid && fix_ch.ready) begin
      total_q.push_back(odometer_step('{lat: fix_ch.lat_e7, lon: fix_ch.lon_e7}));
      n_fix++;
    end
    if (rst_ni && tot_ch.valid && tot_ch.ready) begin
      n_tot++;
      if (total_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected total %0d", tot_ch.total_mm);
      end else if (total_q[0] !== tot_ch.total_mm) begin
        n_err++;
        if (n_err <= 10)
          $display("total mismatch: expected %0d, actual %0d", total_q[0], tot_ch.total_mm);
        void'(total_q.pop_front());
      end else begin
        void'(total_q.pop_front());
      end
    end
  end

  task automatic write_radius(input logic [RAD_W-1:0] r);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_RADIUS; pwdata <= {8'h0, r};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    radius_m = r;
    n_rad++;
  endtask

  task automatic wait_idle();
    while (fix_q.size() > 0 || fix_ch.valid || total_q.size() > 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  function automatic fix_t rand_fix(bit wild);
    fix_t f;
    if (wild) begin
      f.lat = LAT_W'($urandom());
      f.lon = LON_W'($urandom());
    end else begin
      f.lat = LAT_W'($signed($urandom_range(0, 1800000000)) - 900000000);
      f.lon = LON_W'($signed($urandom_range(0, 3600000000)) - 1800000000);
    end
    return f;
  endfunction

  // short hops near the previous point, the usual GPS track
  function automatic fix_t near_fix(fix_t p);
    fix_t f;
    f.lat = LAT_W'(p.lat + $signed($urandom_range(0, 200000)) - 100000);
    f.lon = LON_W'(p.lon + $signed($urandom_range(0, 200000)) - 100000);
    return f;
  endfunction

  initial begin
    fix_t f;
    fix_ch.valid = 1'b0;
    fix_ch.lat_e7 = '0;
    fix_ch.lon_e7 = '0;
    tot_ch.ready = 1'b0;
    radius_m = RADIUS_RESET;
    prev_lat = 0; prev_lon = 0; got_first = 1'b0; run_total = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    drv_en = 1'b1;

    // directed: first fix, poles, antimeridian, beyond-range and extreme codes
    fix_q.push_back('{lat: 0, lon: 0});
    fix_q.push_back('{lat: 0, lon: 0});
    fix_q.push_back('{lat: 900000000, lon: 0});
    fix_q.push_back('{lat: -900000000, lon: 1800000000});
    fix_q.push_back('{lat: 0, lon: -1800000000});
    fix_q.push_back('{lat: 0, lon: 1799999999});
    fix_q.push_back('{lat: 31'sh3FFFFFFF, lon: 32'sh7FFFFFFF});
    fix_q.push_back('{lat: 31'sh40000000, lon: 32'sh80000000});
    fix_q.push_back('{lat: -1, lon: -1});
    fix_q.push_back('{lat: 1, lon: 1});
    fix_q.push_back('{lat: 1200000000, lon: 500000000});
    fix_q.push_back('{lat: -1000000000, lon: -700000000});
    fix_q.push_back('{lat: 515000000, lon: -1000000});
    fix_q.push_back('{lat: 407000000, lon: -740000000});
    wait_idle();

    write_radius('0);
    fix_q.push_back('{lat: 100000000, lon: 100000000});
    fix_q.push_back('{lat: -100000000, lon: -900000000});
    wait_idle();
    write_radius(24'hFFFFFF);
    fix_q.push_back('{lat: 900000000, lon: 0});
    fix_q.push_back('{lat: -900000000, lon: 0});
    wait_idle();
    write_radius(24'd1);
    fix_q.push_back('{lat: 0, lon: 1800000000});
    wait_idle();

    // random phases with varying radii
    for (int ph = 0; ph < 4; ph++) begin
      write_radius(ph == 3 ? RADIUS_RESET : RAD_W'($urandom_range(1, 24'hFFFFFF)));
      f = rand_fix(1'b0);
      for (int k = 0; k < 210; k++) begin
        case ($urandom_range(0, 9))
          0:       f = rand_fix(1'b1);
          1, 2:    f = rand_fix(1'b0);
          default: f = near_fix(f);
        endcase
        fix_q.push_back(f);
      end
      wait_idle();
    end

    $display("covered %0d fixes, %0d totals checked, %0d radius writes",
             n_fix, n_tot, n_rad);
    if (n_err == 0 && total_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("mismatches: %0d, left over: %0d", n_err, total_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end
endmodule

### haversine_path_odometer.f
hw/rtl/hpo_pkg.sv
hw/rtl/hpo_fix_if.sv
hw/rtl/hpo_total_if.sv
hw/rtl/hpo_ctrl.sv
hw/rtl/hpo_dp.sv
hw/rtl/haversine_path_odometer.sv
verif/tb_top.sv
